// ===== rtl/core/qph_pkg.sv =====
// package for the quadratic probe hash table unit
// holds opcodes, controller states and the command and status bundles
// no dependencies
package qph_pkg;

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   typedef logic [1:0] op_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_SEARCH = 2'd2;
   localparam op_type OP_NOP    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_INIT,
      ST_PROBE,
      ST_FINISH
   } qph_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic hash_step;
      logic probe_init;
      logic probe;
      logic commit;
      logic rsp_load;
   } qph_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic hash_last;
      logic op_none;
      logic hit;
      logic probe_over;
      logic rsp_free;
   } qph_status_type;

endpackage

// ===== rtl/core/qph_datapath.sv =====
// datapath of the quadratic probe hash table unit: slot memory, home slot
// reduction, probe address generation, occupancy count and result register
// depends on qph_pkg
module qph_datapath #(
   parameter int SLOTS     = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  qph_pkg::op_type             req_op,
   input  logic [qph_pkg::KEY_W-1:0]   req_key,
   input  logic [qph_pkg::DATA_W-1:0]  req_data_in,
   input  logic                        rsp_stall,
   input  qph_pkg::qph_cmd_type        cmd,
   output qph_pkg::qph_status_type     stat,
   output logic                        rsp_valid,
   output logic                        rsp_success,
   output logic [qph_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [qph_pkg::COUNT_W-1:0] rsp_entry_count
);
   import qph_pkg::*;

   localparam int IdxBits   = $clog2(SLOTS);
   localparam int CntBits   = $clog2(SLOTS + 1);
   localparam int StoreBits = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
   localparam int EntryBits = 1 + KEY_W + StoreBits;
   localparam int HashSteps = 2;
   localparam int HashBits  = $clog2(HashSteps);
   localparam bit Pow2      = (SLOTS & (SLOTS - 1)) == 0;
   localparam logic [IdxBits:0]   SlotsWide = (IdxBits + 1)'(SLOTS);
   localparam logic [CntBits-1:0] SlotsCnt  = CntBits'(SLOTS);
   localparam logic [KEY_W-1:0]   Recip     = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));

   // slot memory: occupied flag, key, data
   logic [EntryBits-1:0] mem [SLOTS];

   op_type                op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [StoreBits-1:0]  data_ff;
   logic [IdxBits:0]      quot_ff;
   logic [IdxBits-1:0]    rem_ff, rem_in;
   logic [HashBits-1:0]   hash_cnt_ff;
   logic [IdxBits-1:0]    pos_ff, pos_in;
   logic [IdxBits-1:0]    odd_ff, odd_in;
   logic [CntBits-1:0]    issue_cnt_ff;
   logic                  chk_valid_ff;
   logic [IdxBits-1:0]    chk_addr_ff;
   logic [EntryBits-1:0]  rd_ff;
   logic [CntBits-1:0]    count_ff;
   logic                  res_ok_ff;
   logic [StoreBits-1:0]  res_data_ff;
   logic [IdxBits-1:0]    clr_cnt_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_success_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [2*KEY_W-1:0]    recip_prod;
   logic [2*IdxBits+1:0]  qd_prod;
   logic [IdxBits:0]      rem_wide, pos_sum, odd_sum;
   logic                  issuing;
   logic                  rd_occ;
   logic [KEY_W-1:0]      rd_key;
   logic [StoreBits-1:0]  rd_data;
   logic                  hit;

   // home slot by reciprocal multiplication; the estimate is low by at most
   // one table size, so one compare and subtract finishes it
   always_comb begin
      recip_prod = {{KEY_W{1'b0}}, key_ff} * {{KEY_W{1'b0}}, Recip};
      qd_prod    = {{(IdxBits + 1){1'b0}}, quot_ff} * {{(IdxBits + 1){1'b0}}, SlotsWide};
      rem_wide   = key_ff[IdxBits:0] - qd_prod[IdxBits:0];
      if (rem_wide >= SlotsWide) begin
         rem_wide = rem_wide - SlotsWide;
      end
      rem_in = rem_wide[IdxBits-1:0];
   end

   // next probe slot: add the running odd step, wrap once
   always_comb begin
      pos_sum = {1'b0, pos_ff} + {1'b0, odd_ff};
      if (pos_sum >= SlotsWide) begin
         pos_sum = pos_sum - SlotsWide;
      end
      pos_in = pos_sum[IdxBits-1:0];
      odd_sum = {1'b0, odd_ff} + (IdxBits + 1)'(2);
      if (odd_sum >= SlotsWide) begin
         odd_sum = odd_sum - SlotsWide;
      end
      odd_in = odd_sum[IdxBits-1:0];
   end

   // entry under check
   assign issuing = cmd.probe && (issue_cnt_ff != SlotsCnt);
   assign rd_occ  = rd_ff[EntryBits-1];
   assign rd_key  = rd_ff[EntryBits-2 -: KEY_W];
   assign rd_data = rd_ff[StoreBits-1:0];
   assign hit     = chk_valid_ff && ((op_ff == OP_INSERT) ? !rd_occ
                                     : (rd_occ && (rd_key == key_ff)));

   // status towards the controller
   always_comb begin
      stat.clear_last = clr_cnt_ff == IdxBits'(SLOTS - 1);
      stat.hash_last  = hash_cnt_ff == HashBits'(HashSteps - 1);
      stat.op_none    = op_ff == OP_NOP;
      stat.hit        = hit;
      stat.probe_over = !chk_valid_ff && (issue_cnt_ff == SlotsCnt);
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // slot memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.commit && (op_ff == OP_INSERT)) begin
         mem[chk_addr_ff] <= {1'b1, key_ff, data_ff};
      end else if (cmd.commit && (op_ff == OP_DELETE)) begin
         mem[chk_addr_ff] <= {1'b0, rd_ff[EntryBits-2:0]};
      end
      if (issuing) begin
         rd_ff <= mem[pos_ff];
      end
   end

   // operation capture and home slot reduction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         key_ff      <= req_key;
         data_ff     <= req_data_in[StoreBits-1:0];
         hash_cnt_ff <= '0;
      end else if (cmd.hash_step) begin
         if (hash_cnt_ff == HashBits'(0)) begin
            quot_ff <= recip_prod[KEY_W +: IdxBits + 1];
         end else begin
            rem_ff  <= rem_in;
         end
         hash_cnt_ff <= hash_cnt_ff + HashBits'(1);
      end
   end

   // probe sequence
   always_ff @(posedge clock) begin
      if (cmd.probe_init) begin
         pos_ff <= Pow2 ? key_ff[IdxBits-1:0] : rem_ff;
         odd_ff <= IdxBits'(1);
      end else if (issuing) begin
         pos_ff      <= pos_in;
         odd_ff      <= odd_in;
         chk_addr_ff <= pos_ff;
      end
   end

   // probe control state
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff <= '0;
         chk_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
      end else begin
         if (cmd.probe_init) begin
            issue_cnt_ff <= '0;
            chk_valid_ff <= 1'b0;
         end else if (cmd.probe) begin
            chk_valid_ff <= issuing;
            if (issuing) begin
               issue_cnt_ff <= issue_cnt_ff + CntBits'(1);
            end
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + IdxBits'(1);
         end
      end
   end

   // occupancy count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit && (op_ff == OP_INSERT)) begin
         count_ff <= count_ff + CntBits'(1);
      end else if (cmd.commit && (op_ff == OP_DELETE)) begin
         count_ff <= count_ff - CntBits'(1);
      end
   end

   // result of the current operation
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ok_ff   <= 1'b0;
         res_data_ff <= '0;
      end else if (cmd.commit) begin
         res_ok_ff <= 1'b1;
         if (op_ff == OP_SEARCH) begin
            res_data_ff <= rd_data;
         end
      end
   end

   // output register, holds the beat while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_success_ff <= res_ok_ff;
         rsp_data_ff    <= DATA_W'(res_data_ff);
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/core/qph_controller.sv =====
// controller of the quadratic probe hash table unit: sequences clearing,
// home slot reduction, probing and result hand-off
// depends on qph_pkg
module qph_controller #(
   parameter int SLOTS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  qph_pkg::qph_status_type stat,
   output qph_pkg::qph_cmd_type    cmd
);
   import qph_pkg::*;

   localparam bit Pow2 = (SLOTS & (SLOTS - 1)) == 0;

   qph_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = Pow2 ? ST_INIT : ST_HASH;
         end
         ST_HASH: begin
            if (stat.hash_last) state_in = ST_INIT;
         end
         ST_INIT: begin
            state_in = stat.op_none ? ST_FINISH : ST_PROBE;
         end
         ST_PROBE: begin
            if (stat.hit || stat.probe_over) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_HASH:  cmd.hash_step  = 1'b1;
         ST_INIT:  cmd.probe_init = 1'b1;
         ST_PROBE: begin
            cmd.probe  = 1'b1;
            cmd.commit = stat.hit;
         end
         ST_FINISH: cmd.rsp_load = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/core/quadratic_probe_hash_table_unit.sv =====
// top level of the quadratic probe hash table unit
// depends on qph_pkg, qph_controller and qph_datapath
//
// Open addressing hash table of SLOTS entries with quadratic probing from
// the home slot (key mod SLOTS). One request beat is an insert, delete, search
// or no-op and gives exactly one response beat with success, the found data
// word (search only, else zero) and the occupied count after the operation.
// After reset a clearing pass writes every slot, one per cycle, and requests
// are stalled until it is done. One operation is in flight at a time; a home
// slot reduction precedes probing when SLOTS is not a power of two. The probe
// loop reads the slot memory through its single read port once a cycle. A
// finished response waits in an output register, so a new request is taken
// while it is still stalled.
module quadratic_probe_hash_table_unit #(
   parameter int SLOTS     = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  qph_pkg::op_type             req_op,
   input  logic [qph_pkg::KEY_W-1:0]   req_key,
   input  logic [qph_pkg::DATA_W-1:0]  req_data_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_success,
   output logic [qph_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [qph_pkg::COUNT_W-1:0] rsp_entry_count
);
   import qph_pkg::*;

   qph_cmd_type    cmd;
   qph_status_type stat;

   // sequencing
   qph_controller #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   qph_datapath #(
      .SLOTS     (SLOTS),
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_data_in     (req_data_in),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_success     (rsp_success),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== rtl/core/qph_checker.sv =====
// port level checks for the quadratic probe hash table unit
// depends on qph_pkg; bound to quadratic_probe_hash_table_unit
module qph_checker #(
   parameter int SLOTS = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_success,
   input logic [qph_pkg::DATA_W-1:0]  rsp_data_out,
   input logic [qph_pkg::COUNT_W-1:0] rsp_entry_count
);
   import qph_pkg::*;

   // clearing pass holds off requests after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // one operation at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an operation is in flight");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_success)
                                    && $stable(rsp_data_out)
                                    && $stable(rsp_entry_count)))
      else $error("stalled response beat changed");

   // a failed operation returns no data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_data_out == '0))
      else $error("data on a failed response");

   // count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= SLOTS))
      else $error("entry count above table size");

endmodule

bind quadratic_probe_hash_table_unit qph_checker #(
   .SLOTS (SLOTS)
) u_qph_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_success     (rsp_success),
   .rsp_data_out    (rsp_data_out),
   .rsp_entry_count (rsp_entry_count)
);
